// File: rtl/core/monitor_mode_controller_assert.svh
// Assertion macros for the monitor mode controller.
// Each check is sampled on i_clk and is disabled while i_rst_n is low.
`ifndef MONITOR_MODE_CONTROLLER_ASSERT_SVH
`define MONITOR_MODE_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MMC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MMC_ASSERT_SAME(label, ante, cons)

`define MMC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/mmc_pkg.sv
package mmc_pkg;

    typedef enum logic [1:0] {
        MODE_INIT       = 2'd0,
        MODE_MONITORING = 2'd1,
        MODE_ALARM      = 2'd2,
        MODE_STANDBY    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_INIT_DELAY     = 2'd0,
        REG_TICKS_PER_SEC  = 2'd1,
        REG_CHIRP_INTERVAL = 2'd2,
        REG_CHIRP_LENGTH   = 2'd3
    } t_reg_idx;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_TOGGLE = 1'b1;

    localparam logic [15:0] INIT_DELAY_RESET     = 16'd200;
    localparam logic [15:0] TICKS_PER_SEC_RESET  = 16'd100;
    localparam logic [15:0] CHIRP_INTERVAL_RESET = 16'd60;
    localparam logic [7:0]  CHIRP_LENGTH_RESET   = 8'd15;

    localparam int unsigned PADDR_W = 4;

    typedef struct packed {
        logic [15:0] init_delay_ticks;
        logic [15:0] ticks_per_second;
        logic [15:0] chirp_interval_sec;
        logic [7:0]  chirp_length_ticks;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic        tone_on;
        logic [31:0] standby_seconds;
        logic        alarm_service;
    } t_result;

endpackage

// File: rtl/core/mmc_in_if.sv
interface mmc_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic alarm_active;

    modport source (output valid, output req_type, output alarm_active, input ready);
    modport sink (input valid, input req_type, input alarm_active, output ready);
endinterface

// File: rtl/core/mmc_out_if.sv
interface mmc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        tone_on;
    logic [31:0] standby_seconds;
    logic        alarm_service;

    modport source (
        output valid, output mode, output tone_on, output standby_seconds,
        output alarm_service, input ready
    );
    modport sink (
        input valid, input mode, input tone_on, input standby_seconds,
        input alarm_service, output ready
    );
endinterface

// File: rtl/core/monitor_mode_controller.sv
// Mode controller for a patient monitor: every accepted beat (a tick or a standby toggle)
// updates the mode, the standby second count and the reminder tone and yields exactly one
// result beat in the result register on the following cycle. A new beat is taken in every
// cycle as long as the result register is empty or its beat is being taken, so the
// sustained rate is one beat per cycle.
// Configuration registers are written over the APB port at byte addresses 0, 4, 8 and 12
// and should only be changed while no beat is in flight.
`include "monitor_mode_controller_assert.svh"

module monitor_mode_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mmc_in_if.sink                       i_in,
    mmc_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mmc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mmc_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_accept;

    mmc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mmc_mode_core u_mode_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_accept),
        .i_req_type     (i_in.req_type),
        .i_alarm_active (i_in.alarm_active),
        .i_cfg          (w_cfg),
        .o_result       (w_result)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.mode            = r_result.mode;
    assign o_out.tone_on         = r_result.tone_on;
    assign o_out.standby_seconds = r_result.standby_seconds;
    assign o_out.alarm_service   = r_result.alarm_service;

    `MMC_ASSERT_NEXT(a_accept_fills_output, w_accept, r_out_valid)
    `MMC_ASSERT_SAME(a_tone_only_in_standby, r_out_valid && r_result.tone_on, r_result.mode == MODE_STANDBY)
    `MMC_ASSERT_SAME(a_seconds_only_in_standby, r_out_valid && (r_result.standby_seconds != 32'd0), r_result.mode == MODE_STANDBY)
    `MMC_ASSERT_SAME(a_no_service_in_init, r_out_valid && r_result.alarm_service, r_result.mode != MODE_INIT)
endmodule

// File: rtl/core/mmc_cfg_regs.sv
module mmc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mmc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output mmc_pkg::t_cfg                o_cfg
);
    import mmc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_delay_ticks   <= INIT_DELAY_RESET;
            r_cfg.ticks_per_second   <= TICKS_PER_SEC_RESET;
            r_cfg.chirp_interval_sec <= CHIRP_INTERVAL_RESET;
            r_cfg.chirp_length_ticks <= CHIRP_LENGTH_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_INIT_DELAY:     r_cfg.init_delay_ticks   <= pwdata[15:0];
                REG_TICKS_PER_SEC:  r_cfg.ticks_per_second   <= pwdata[15:0];
                REG_CHIRP_INTERVAL: r_cfg.chirp_interval_sec <= pwdata[15:0];
                REG_CHIRP_LENGTH:   r_cfg.chirp_length_ticks <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INIT_DELAY:     prdata = {16'd0, r_cfg.init_delay_ticks};
            REG_TICKS_PER_SEC:  prdata = {16'd0, r_cfg.ticks_per_second};
            REG_CHIRP_INTERVAL: prdata = {16'd0, r_cfg.chirp_interval_sec};
            REG_CHIRP_LENGTH:   prdata = {24'd0, r_cfg.chirp_length_ticks};
        endcase
    end
endmodule

// File: rtl/core/mmc_mode_core.sv
module mmc_mode_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_req_type,
    input  logic             i_alarm_active,
    input  mmc_pkg::t_cfg    i_cfg,
    output mmc_pkg::t_result o_result
);
    import mmc_pkg::*;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [15:0] r_init_count;
    logic [15:0] n_init_count;
    logic [15:0] r_prescale;
    logic [15:0] n_prescale;
    logic [31:0] r_seconds;
    logic [31:0] n_seconds;
    logic [15:0] r_interval;
    logic [15:0] n_interval;
    logic [7:0]  r_chirp_count;
    logic [7:0]  n_chirp_count;
    logic        r_tone;
    logic        n_tone;
    logic        w_service;
    logic [15:0] w_init_inc;

    assign w_init_inc = r_init_count + 16'd1;

    always_comb begin
        n_mode = r_mode;
        if (i_req_type == REQ_TOGGLE) begin
            unique case (r_mode)
                MODE_INIT:    n_mode = MODE_INIT;
                MODE_STANDBY: n_mode = MODE_MONITORING;
                MODE_MONITORING, MODE_ALARM: n_mode = MODE_STANDBY;
            endcase
        end else begin
            unique case (r_mode)
                MODE_INIT: begin
                    if (w_init_inc >= i_cfg.init_delay_ticks) begin
                        n_mode = MODE_MONITORING;
                    end
                end
                MODE_STANDBY: n_mode = MODE_STANDBY;
                MODE_MONITORING, MODE_ALARM: begin
                    n_mode = i_alarm_active ? MODE_ALARM : MODE_MONITORING;
                end
            endcase
        end
    end

    always_comb begin
        logic [15:0] v_pre_inc;
        logic [15:0] v_int_inc;
        n_init_count  = r_init_count;
        n_prescale    = r_prescale;
        n_seconds     = r_seconds;
        n_interval    = r_interval;
        n_chirp_count = r_chirp_count;
        n_tone        = r_tone;
        w_service     = 1'b0;
        v_pre_inc     = r_prescale + 16'd1;
        v_int_inc     = r_interval + 16'd1;
        if (i_req_type == REQ_TOGGLE) begin
            if (r_mode != MODE_INIT) begin
                n_prescale    = '0;
                n_seconds     = '0;
                n_interval    = '0;
                n_chirp_count = '0;
                n_tone        = 1'b0;
                w_service     = 1'b1;
            end
        end else begin
            unique case (r_mode)
                MODE_INIT: n_init_count = w_init_inc;
                MODE_STANDBY: begin
                    n_prescale = v_pre_inc;
                    if (v_pre_inc >= i_cfg.ticks_per_second) begin
                        n_prescale = '0;
                        n_seconds  = r_seconds + 32'd1;
                        n_interval = v_int_inc;
                        if (v_int_inc >= i_cfg.chirp_interval_sec) begin
                            n_interval    = '0;
                            n_chirp_count = i_cfg.chirp_length_ticks;
                            n_tone        = 1'b1;
                        end
                    end
                    if (n_chirp_count != 8'd0) begin
                        n_chirp_count = n_chirp_count - 8'd1;
                        if (n_chirp_count == 8'd0) begin
                            n_tone = 1'b0;
                        end
                    end
                end
                MODE_MONITORING, MODE_ALARM: w_service = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_INIT;
            r_init_count  <= '0;
            r_prescale    <= '0;
            r_seconds     <= '0;
            r_interval    <= '0;
            r_chirp_count <= '0;
            r_tone        <= 1'b0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_init_count  <= n_init_count;
            r_prescale    <= n_prescale;
            r_seconds     <= n_seconds;
            r_interval    <= n_interval;
            r_chirp_count <= n_chirp_count;
            r_tone        <= n_tone;
        end
    end

    assign o_result.mode            = n_mode;
    assign o_result.tone_on         = n_tone;
    assign o_result.standby_seconds = n_seconds;
    assign o_result.alarm_service   = w_service;
endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mmc_pkg::*;

    class mode_tracker;
        t_cfg        cfg;
        t_mode       mode_q;
        logic [15:0] init_ticks;
        logic [15:0] prescale;
        logic [15:0] interval_secs;
        logic [31:0] seconds;
        logic [7:0]  chirp_left;
        logic        tone;
        t_result     expected_results[$];
        int unsigned failures;

        function new();
            cfg.init_delay_ticks   = INIT_DELAY_RESET;
            cfg.ticks_per_second   = TICKS_PER_SEC_RESET;
            cfg.chirp_interval_sec = CHIRP_INTERVAL_RESET;
            cfg.chirp_length_ticks = CHIRP_LENGTH_RESET;
            mode_q     = MODE_INIT;
            init_ticks = '0;
            failures   = 0;
            clear_standby();
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_INIT_DELAY:     cfg.init_delay_ticks   = value[15:0];
                REG_TICKS_PER_SEC:  cfg.ticks_per_second   = value[15:0];
                REG_CHIRP_INTERVAL: cfg.chirp_interval_sec = value[15:0];
                REG_CHIRP_LENGTH:   cfg.chirp_length_ticks = value[7:0];
                default: ;
            endcase
        endfunction

        function void clear_standby();
            prescale      = '0;
            seconds       = '0;
            interval_secs = '0;
            chirp_left    = '0;
            tone          = 1'b0;
        endfunction

        function void standby_tick();
            prescale = prescale + 16'd1;
            if (prescale >= cfg.ticks_per_second) begin
                prescale      = '0;
                seconds       = seconds + 32'd1;
                interval_secs = interval_secs + 16'd1;
                if (interval_secs >= cfg.chirp_interval_sec) begin
                    interval_secs = '0;
                    chirp_left    = cfg.chirp_length_ticks;
                    tone          = 1'b1;
                end
            end
            if (chirp_left != 8'd0) begin
                chirp_left = chirp_left - 8'd1;
                if (chirp_left == 8'd0) begin
                    tone = 1'b0;
                end
            end
        endfunction

        function void note_beat(logic req_type, logic alarm_active);
            t_result res;
            logic    service;
            service = 1'b0;
            if (req_type == REQ_TOGGLE) begin
                if (mode_q == MODE_STANDBY) begin
                    mode_q = MODE_MONITORING;
                    clear_standby();
                    service = 1'b1;
                end else if (mode_q != MODE_INIT) begin
                    mode_q = MODE_STANDBY;
                    clear_standby();
                    service = 1'b1;
                end
            end else begin
                case (mode_q)
                    MODE_INIT: begin
                        init_ticks = init_ticks + 16'd1;
                        if (init_ticks >= cfg.init_delay_ticks) begin
                            mode_q = MODE_MONITORING;
                        end
                    end
                    MODE_STANDBY: begin
                        standby_tick();
                    end
                    default: begin
                        service = 1'b1;
                        mode_q  = alarm_active ? MODE_ALARM : MODE_MONITORING;
                    end
                endcase
            end
            res.mode            = mode_q;
            res.tone_on         = tone;
            res.standby_seconds = seconds;
            res.alarm_service   = service;
            expected_results.push_back(res);
        endfunction

        function void check_beat(logic [1:0] mode, logic tone_on, logic [31:0] secs,
                                 logic service);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation: mode %0d", mode);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (want.mode !== mode) begin
                $error("mode: expected %0d, actual %0d", want.mode, mode);
                failures++;
            end
            if (want.tone_on !== tone_on) begin
                $error("tone_on: expected %0d, actual %0d", want.tone_on, tone_on);
                failures++;
            end
            if (want.standby_seconds !== secs) begin
                $error("standby_seconds: expected %0d, actual %0d", want.standby_seconds, secs);
                failures++;
            end
            if (want.alarm_service !== service) begin
                $error("alarm_service: expected %0d, actual %0d", want.alarm_service, service);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    mmc_in_if  in_bus ();
    mmc_out_if out_bus ();

    mode_tracker tracker = new();

    logic [15:0] stall_pattern;
    logic [5:0]  stall_pos;
    int unsigned burst_left;
    int unsigned gap_max;

    monitor_mode_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("monitor_mode_controller verification failed");
        $finish;
    end

    // The receiver stalls on a 16-bit pattern that is redrawn whenever the 6-bit stall_pos wraps.
    always @(posedge i_clk) begin
        if (stall_pos == 6'd63) begin
            if ($urandom_range(0, 3) == 0) begin
                stall_pattern <= 16'hFFFF;
            end else begin
                stall_pattern <= 16'($urandom()) | 16'h0001;
            end
        end
        stall_pos     <= stall_pos + 6'd1;
        out_bus.ready <= stall_pattern[stall_pos[3:0]];
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                tracker.note_beat(in_bus.req_type, in_bus.alarm_active);
            end
            if (out_bus.valid && out_bus.ready) begin
                tracker.check_beat(out_bus.mode, out_bus.tone_on, out_bus.standby_seconds,
                                   out_bus.alarm_service);
            end
        end
    end

    task automatic write_register(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_settings(logic [15:0] init_delay, logic [15:0] tps,
                                    logic [15:0] interval, logic [7:0] length);
        write_register(REG_INIT_DELAY, ($urandom() & 32'hFFFF_0000) | init_delay);
        write_register(REG_TICKS_PER_SEC, ($urandom() & 32'hFFFF_0000) | tps);
        write_register(REG_CHIRP_INTERVAL, ($urandom() & 32'hFFFF_0000) | interval);
        write_register(REG_CHIRP_LENGTH, ($urandom() & 32'hFFFF_FF00) | length);
    endtask

    task automatic send_beat(logic req_type, logic alarm_active);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max != 0) ? $urandom_range(0, gap_max) : 0;
            if (gap != 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_bus.valid        <= 1'b1;
        in_bus.req_type     <= req_type;
        in_bus.alarm_active <= alarm_active;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Toggles are kept rare so that standby stretches run long enough to chirp.
    task automatic random_beats(int unsigned count, int unsigned toggle_odds);
        logic req;
        for (int unsigned i = 0; i < count; i++) begin
            req = ($urandom_range(0, toggle_odds - 1) == 0) ? REQ_TOGGLE : REQ_TICK;
            send_beat(req, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(int unsigned gaps, logic [15:0] init_delay, logic [15:0] tps,
                             logic [15:0] interval, logic [7:0] length,
                             int unsigned count, int unsigned toggle_odds);
        settle();
        program_settings(init_delay, tps, interval, length);
        gap_max = gaps;
        random_beats(count, toggle_odds);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_bus.valid        = 1'b0;
        in_bus.req_type     = REQ_TICK;
        in_bus.alarm_active = 1'b0;
        out_bus.ready       = 1'b0;
        stall_pattern       = 16'hFFFF;
        stall_pos           = '0;
        burst_left          = 0;
        gap_max             = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Toggles are ignored in init, and the fourth tick enters monitoring.
        write_register(REG_INIT_DELAY, 32'd4);
        send_beat(REQ_TOGGLE, 1'b1);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_TICK, 1'b0);
        send_beat(REQ_TOGGLE, 1'b0);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_TICK, 1'b0);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_TICK, 1'b0);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_TOGGLE, 1'b1);
        send_beat(REQ_TICK, 1'b0);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_TOGGLE, 1'b0);
        send_beat(REQ_TOGGLE, 1'b1);
        send_beat(REQ_TOGGLE, 1'b0);

        // With all timing registers at zero, every standby tick is a second that starts an
        // endless chirp, which only a toggle mutes.
        settle();
        program_settings(16'd0, 16'd0, 16'd0, 8'd0);
        send_beat(REQ_TOGGLE, 1'b0);
        send_beat(REQ_TICK, 1'b0);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_TICK, 1'b0);
        send_beat(REQ_TOGGLE, 1'b1);
        random_beats(200, 16);

        run_phase(4, 16'd1, 16'd1, 16'd1, 8'd1, 200, 24);
        run_phase(6, 16'hFFFF, 16'd3, 16'd2, 8'd2, 200, 32);
        run_phase(2, 16'd200, 16'd2, 16'd3, 8'hFF, 200, 64);
        run_phase(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 100, 20);
        run_phase(3, 16'd0, 16'd0, 16'd1, 8'd0, 200, 40);
        for (int p = 0; p < 3; p++) begin
            run_phase($urandom_range(0, 5), 16'($urandom()), 16'($urandom_range(0, 5)),
                      16'($urandom_range(0, 5)), 8'($urandom_range(0, 8)), 250, 32);
        end

        settle();
        if (tracker.pending() != 0) begin
            $error("%0d expected result beats never arrived", tracker.pending());
        end
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("monitor_mode_controller verification clean");
        end else begin
            $display("monitor_mode_controller verification failed");
        end
        $finish;
    end
endmodule
